// ===== rtl/core/ldim_pkg.sv =====
// Package for the lens distortion index map core.
// Fixed-point widths, register indexes and saturating Q4.28 helpers.
// No dependencies.
package ldim_pkg;

    localparam int Q_FRAC    = 28;
    localparam int PIX_FRAC  = 20;
    localparam int NUM_W     = 34;
    localparam int COORD_W   = 13;
    localparam int INDEX_W   = 18;
    localparam int CFG_IDX_W = 3;
    localparam int DIV_BITS  = 32;

    localparam logic signed [63:0] SAT_MAX = 64'sd2147483647;
    localparam logic signed [63:0] SAT_MIN = -64'sd2147483648;
    localparam logic signed [63:0] Q_ONE   = 64'sd268435456;
    localparam logic signed [63:0] HALF_PX = 64'sd524288;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FOCAL_X   = 3'd0,
        CFG_FOCAL_Y   = 3'd1,
        CFG_CENTER_X  = 3'd2,
        CFG_CENTER_Y  = 3'd3,
        CFG_RADIAL_K1 = 3'd4,
        CFG_RADIAL_K2 = 3'd5,
        CFG_RADIAL_K3 = 3'd6,
        CFG_TANGENT   = 3'd7
    } t_cfg_index;

    function automatic logic signed [63:0] sext32(input logic signed [31:0] v);
        return {{32{v[31]}}, v};
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
        logic signed [31:0] r;
        if (v > SAT_MAX) begin
            r = 32'sh7fffffff;
        end else if (v < SAT_MIN) begin
            r = 32'sh80000000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

    function automatic logic signed [31:0] qscale(input logic signed [63:0] p);
        return sat32(p >>> Q_FRAC);
    endfunction

endpackage

// ===== rtl/core/ldim_div.sv =====
// Pipelined restoring divider for coordinate normalization.
// Computes sat32(trunc(num * 2^28 / den)), one quotient bit per stage.
// Depends on ldim_pkg.
module ldim_div import ldim_pkg::*; (
    input  logic                    i_clk,
    input  logic                    i_en,
    input  logic signed [NUM_W-1:0] i_num,
    input  logic [30:0]             i_den,
    output logic signed [31:0]      o_quo
);

    logic [63:0]         r_rem [0:DIV_BITS];
    logic [DIV_BITS-1:0] r_quo [0:DIV_BITS];
    logic                r_neg [0:DIV_BITS];
    logic                r_ovf [0:DIV_BITS];
    logic signed [31:0]  r_out;
    logic [NUM_W-1:0]    w_mag;

    assign w_mag = i_num[NUM_W-1] ? NUM_W'(-i_num) : NUM_W'(i_num);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem[0] <= 64'(w_mag) << Q_FRAC;
            r_quo[0] <= '0;
            r_neg[0] <= i_num[NUM_W-1];
            r_ovf[0] <= 35'(w_mag) >= {i_den, 4'b0};
        end
    end

    for (genvar k = 0; k < DIV_BITS; k++) begin : g_bit
        logic [63:0] w_sub;
        assign w_sub = 64'(i_den) << (DIV_BITS - 1 - k);
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_neg[k+1] <= r_neg[k];
                r_ovf[k+1] <= r_ovf[k];
                if (r_rem[k] >= w_sub) begin
                    r_rem[k+1] <= r_rem[k] - w_sub;
                    r_quo[k+1] <= r_quo[k] | (DIV_BITS'(1) << (DIV_BITS - 1 - k));
                end else begin
                    r_rem[k+1] <= r_rem[k];
                    r_quo[k+1] <= r_quo[k];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (!r_neg[DIV_BITS]) begin
                if (r_ovf[DIV_BITS] || r_quo[DIV_BITS][31]) begin
                    r_out <= 32'sh7fffffff;
                end else begin
                    r_out <= $signed(r_quo[DIV_BITS]);
                end
            end else begin
                if (r_ovf[DIV_BITS] || r_quo[DIV_BITS] > 32'h80000000) begin
                    r_out <= 32'sh80000000;
                end else begin
                    r_out <= $signed(-r_quo[DIV_BITS]);
                end
            end
        end
    end

    assign o_quo = r_out;

endmodule

// ===== rtl/core/lens_distortion_index_map_core.sv =====
// Lens distortion index map: Brown-Conrady remap of one depth pixel per clock while not stalled.
// Top level; depends on ldim_pkg and ldim_div.
//
// One item enters per clock while the output is not stalled; each passes through the
// 32-stage normalizing divider (one quotient bit per stage) followed by the fixed-point
// polynomial stages. The whole pipeline holds while a finished result is stalled at the
// output. Configuration registers are read live by the stages that use them, so write
// them only while no item is in flight.
module lens_distortion_index_map_core import ldim_pkg::*; #(
    parameter int IMAGE_WIDTH  = 512,
    parameter int IMAGE_HEIGHT = 424
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_stall,
    input  logic [8:0]           i_pixel_col,
    input  logic [8:0]           i_pixel_row,
    output logic                 o_valid,
    input  logic                 i_stall,
    output logic                 o_in_image,
    output logic [INDEX_W-1:0]   o_source_index,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [63:0]          i_cfg_data
);

    localparam int LAT = 48;
    localparam logic signed [63:0] W_S = 64'(IMAGE_WIDTH);
    localparam logic signed [63:0] H_S = 64'(IMAGE_HEIGHT);

    logic [30:0]        r_fx, r_fy;
    logic signed [31:0] r_cx, r_cy, r_k1, r_k2, r_k3, r_p1, r_p2;
    logic [LAT-1:0]     r_vld;
    logic               w_en;
    logic [30:0]        w_fx_div, w_fy_div;

    logic signed [NUM_W-1:0] r_nx, r_ny;
    logic signed [31:0] w_dx, w_dy;

    logic signed [63:0] r_mxx, r_myy, r_mxy, r_m3, r_m5, r_m7, r_mkx, r_mky, r_px, r_py;
    logic signed [63:0] r_tpa, r_tpb, r_tpc, r_tpd, r_vx, r_vy;
    logic signed [31:0] r_dx1, r_dy1, r_dx2, r_dy2, r_dx3, r_dy3, r_dx4, r_dy4;
    logic signed [31:0] r_dx5, r_dy5, r_dx6, r_dy6, r_dx7, r_dy7, r_dx8, r_dy8;
    logic signed [31:0] r_sxx, r_syy, r_r2, r_xy2, r_r2b, r_xy2b, r_ax, r_ay;
    logic signed [31:0] r_r2c, r_r2d, r_r2e, r_t1, r_t2, r_kr;
    logic signed [31:0] r_qa, r_qb, r_qc, r_qd, r_qa7, r_qb7, r_qc7, r_qd7;
    logic signed [31:0] r_qa8, r_qb8, r_qc8, r_qd8, r_qa9, r_qb9, r_qc9, r_qd9;
    logic signed [31:0] r_qa10, r_qb10, r_qc10, r_qd10;
    logic signed [31:0] r_ux, r_uy;
    logic               r_in_image;
    logic [INDEX_W-1:0] r_index;

    logic signed [31:0] w_sxx, w_syy;
    logic signed [63:0] w_ix, w_iy;
    logic [31:0]        w_lin;

    assign w_en        = !(r_vld[LAT-1] && i_stall);
    assign o_stall     = !w_en;
    assign o_valid     = r_vld[LAT-1];
    assign o_cfg_ready = 1'b1;
    assign w_fx_div    = (r_fx == '0) ? 31'd1 : r_fx;
    assign w_fy_div    = (r_fy == '0) ? 31'd1 : r_fy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fx <= 31'd1048576;
            r_fy <= 31'd1048576;
            r_cx <= '0;
            r_cy <= '0;
            r_k1 <= '0;
            r_k2 <= '0;
            r_k3 <= '0;
            r_p1 <= '0;
            r_p2 <= '0;
        end else if (i_cfg_valid) begin
            case (t_cfg_index'(i_cfg_index))
                CFG_FOCAL_X:   r_fx <= i_cfg_data[30:0];
                CFG_FOCAL_Y:   r_fy <= i_cfg_data[30:0];
                CFG_CENTER_X:  r_cx <= i_cfg_data[31:0];
                CFG_CENTER_Y:  r_cy <= i_cfg_data[31:0];
                CFG_RADIAL_K1: r_k1 <= i_cfg_data[31:0];
                CFG_RADIAL_K2: r_k2 <= i_cfg_data[31:0];
                CFG_RADIAL_K3: r_k3 <= i_cfg_data[31:0];
                CFG_TANGENT: begin
                    r_p1 <= i_cfg_data[31:0];
                    r_p2 <= i_cfg_data[63:32];
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= {r_vld[LAT-2:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_nx <= $signed({5'b0, i_pixel_col, 20'b0}) - NUM_W'(r_cx);
            r_ny <= $signed({5'b0, i_pixel_row, 20'b0}) - NUM_W'(r_cy);
        end
    end

    ldim_div u_div_x (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_num (r_nx),
        .i_den (w_fx_div),
        .o_quo (w_dx)
    );

    ldim_div u_div_y (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_num (r_ny),
        .i_den (w_fy_div),
        .o_quo (w_dy)
    );

    assign w_sxx = qscale(r_mxx);
    assign w_syy = qscale(r_myy);

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            // square terms
            r_mxx <= w_dx * w_dx;
            r_myy <= w_dy * w_dy;
            r_mxy <= w_dx * w_dy;
            r_dx1 <= w_dx;
            r_dy1 <= w_dy;
            r_sxx <= w_sxx;
            r_syy <= w_syy;
            r_r2  <= sat32(sext32(w_sxx) + sext32(w_syy));
            r_xy2 <= sat32(sext32(qscale(r_mxy)) + sext32(qscale(r_mxy)));
            r_dx2 <= r_dx1;
            r_dy2 <= r_dy1;
            // tangential brackets and k3 term
            r_ax   <= sat32(sext32(r_r2) + sext32(r_sxx) + sext32(r_sxx));
            r_ay   <= sat32(sext32(r_r2) + sext32(r_syy) + sext32(r_syy));
            r_m3   <= r_k3 * r_r2;
            r_r2b  <= r_r2;
            r_xy2b <= r_xy2;
            r_dx3  <= r_dx2;
            r_dy3  <= r_dy2;
            r_t1  <= sat32(sext32(qscale(r_m3)) + sext32(r_k2));
            r_tpa <= r_p2 * r_ax;
            r_tpb <= r_p1 * r_xy2b;
            r_tpc <= r_p1 * r_ay;
            r_tpd <= r_p2 * r_xy2b;
            r_r2c <= r_r2b;
            r_dx4 <= r_dx3;
            r_dy4 <= r_dy3;
            r_m5  <= r_t1 * r_r2c;
            r_qa  <= qscale(r_tpa);
            r_qb  <= qscale(r_tpb);
            r_qc  <= qscale(r_tpc);
            r_qd  <= qscale(r_tpd);
            r_r2d <= r_r2c;
            r_dx5 <= r_dx4;
            r_dy5 <= r_dy4;
            r_t2  <= sat32(sext32(qscale(r_m5)) + sext32(r_k1));
            r_qa7 <= r_qa;
            r_qb7 <= r_qb;
            r_qc7 <= r_qc;
            r_qd7 <= r_qd;
            r_r2e <= r_r2d;
            r_dx6 <= r_dx5;
            r_dy6 <= r_dy5;
            r_m7  <= r_t2 * r_r2e;
            r_qa8 <= r_qa7;
            r_qb8 <= r_qb7;
            r_qc8 <= r_qc7;
            r_qd8 <= r_qd7;
            r_dx7 <= r_dx6;
            r_dy7 <= r_dy6;
            r_kr  <= sat32(Q_ONE + sext32(qscale(r_m7)));
            r_qa9 <= r_qa8;
            r_qb9 <= r_qb8;
            r_qc9 <= r_qc8;
            r_qd9 <= r_qd8;
            r_dx8 <= r_dx7;
            r_dy8 <= r_dy7;
            r_mkx <= r_dx8 * r_kr;
            r_mky <= r_dy8 * r_kr;
            r_qa10 <= r_qa9;
            r_qb10 <= r_qb9;
            r_qc10 <= r_qc9;
            r_qd10 <= r_qd9;
            r_ux  <= sat32(sext32(qscale(r_mkx)) + sext32(r_qa10) + sext32(r_qb10));
            r_uy  <= sat32(sext32(qscale(r_mky)) + sext32(r_qc10) + sext32(r_qd10));
            // back to pixels
            r_px <= $signed({1'b0, r_fx}) * r_ux;
            r_py <= $signed({1'b0, r_fy}) * r_uy;
            r_vx <= (r_px >>> Q_FRAC) + sext32(r_cx) + HALF_PX;
            r_vy <= (r_py >>> Q_FRAC) + sext32(r_cy) + HALF_PX;
            if (w_ix >= 0 && w_ix < W_S && w_iy >= 0 && w_iy < H_S) begin
                r_in_image <= 1'b1;
                r_index    <= w_lin[INDEX_W-1:0];
            end else begin
                r_in_image <= 1'b0;
                r_index    <= '0;
            end
        end
    end

    assign w_ix  = r_vx[63] ? -((-r_vx) >>> PIX_FRAC) : (r_vx >>> PIX_FRAC);
    assign w_iy  = r_vy[63] ? -((-r_vy) >>> PIX_FRAC) : (r_vy >>> PIX_FRAC);
    assign w_lin = 32'(w_iy[COORD_W-1:0]) * 32'(IMAGE_WIDTH) + 32'(w_ix[COORD_W-1:0]);

    assign o_in_image     = r_in_image;
    assign o_source_index = r_index;

endmodule
